// File: rtl/dwcp_pkg.sv
// Shared types and constants for the dual wheel cascaded PI drive.
// Depends on nothing; every other file of the block imports it.
package dwcp_pkg;

    // Encoder counter width (16 to 32); only the low bits of a position are used
    localparam int ENC_W = 32;

    localparam int POS_W   = 32;   // input position field width
    localparam int DIST_W  = 10;
    localparam int GAIN_W  = 32;   // kp / ki_dt registers
    localparam int PGAIN_W = 16;
    localparam int SPD_W   = 16;
    localparam int PWM_W   = 9;
    localparam int TGT_W   = 24;   // speed target, Q.8, never negative
    localparam int HIST_W  = 24;   // raw speed, Q.8 signed
    localparam int INTEG_W = 48;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd6;

    localparam logic [GAIN_W-1:0]  KP_LEFT_RST     = 32'd189583;
    localparam logic [GAIN_W-1:0]  KI_DT_LEFT_RST  = 32'd3882650;
    localparam logic [GAIN_W-1:0]  KP_RIGHT_RST    = 32'd271791;
    localparam logic [GAIN_W-1:0]  KI_DT_RIGHT_RST = 32'd3470334;
    localparam logic [PGAIN_W-1:0] POS_GAIN_RST    = 16'd1280;
    localparam logic [POS_W-1:0]   TARGET_POS_RST  = 32'd1000000;
    localparam logic [SPD_W-1:0]   MAX_SPEED_RST   = 16'd250;

    // Raw speed = delta * 25 in Q.8; beyond +-1310 counts it saturates
    localparam logic signed [ENC_W-1:0]  DELTA_SAT = ENC_W'(1310);
    localparam logic signed [HIST_W-1:0] RAW_MUL   = 24'sd6400;
    localparam logic signed [HIST_W-1:0] HIST_MAX  = 24'sh7FFFFF;
    localparam logic signed [HIST_W-1:0] HIST_MIN  = 24'sh800000;

    // 0.3333 as 21843 / 2^16
    localparam logic signed [41:0] AVG_MUL = 42'sd21843;

    // 57.14 as 3744727 / 2^16, applied to Q.16 u to give Q.32 pwm
    localparam logic [21:0] SCALE_MUL = 22'd3744727;
    // Smallest u whose scaled value pushes the compare value below zero
    localparam logic signed [49:0] U_HIGH = 50'sd458775;
    localparam logic [PWM_W-1:0] PWM_STOP = 9'd400;

    // Division by 5 for the distance ramp: x / 5 = (x * M) >> 30, exact for x < 2^27
    localparam logic [27:0] DIV5_MUL = 28'd214748365;

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Step strobes for one wheel lane
    typedef struct packed {
        logic front;   // delta, raw speed, history sum
        logic filt;    // 3-tap average
        logic err;     // speed error
        logic mult;    // P and I products
        logic integ;   // saturated integral candidate
        logic sum;     // PI sum and saturation flags
        logic scale;   // scaled command, integral commit
        logic pwm;     // compare value
    } lane_ctl_t;

    // Step strobes for the outer position loop
    typedef struct packed {
        logic prep;    // position error, ramp operand
        logic mult;    // gain and ramp products
        logic commit;  // limit and store the speed target
    } outer_ctl_t;

endpackage

// File: rtl/dwcp_outer.sv
// Outer position step: speed target from the mean wheel position, limited by distance.
// Depends on dwcp_pkg.
module dwcp_outer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dwcp_pkg::outer_ctl_t         ctl,
    input  logic [dwcp_pkg::ENC_W-1:0]   left_pos,
    input  logic [dwcp_pkg::ENC_W-1:0]   right_pos,
    input  logic [dwcp_pkg::DIST_W-1:0]  distance,
    input  logic [dwcp_pkg::PGAIN_W-1:0] gain,
    input  logic [dwcp_pkg::POS_W-1:0]   target_pos,
    input  logic [dwcp_pkg::SPD_W-1:0]   max_speed,
    output logic [dwcp_pkg::TGT_W-1:0]   target
);
    import dwcp_pkg::*;

    logic signed [32:0] pos_sum;
    logic signed [40:0] err_next, err_reg;
    logic [DIST_W-1:0]  dist_off;
    logic [21:0]        ramp_next, ramp_reg;
    logic               far_next, far_reg, near_next, near_reg;
    logic signed [57:0] cmd_prod_next, cmd_prod_reg;
    logic [49:0]        ramp_prod;
    logic [TGT_W-1:0]   lim_next, lim_reg;
    logic signed [49:0] cmd;
    logic [TGT_W-1:0]   target_next, target_reg;

    always_comb begin
        pos_sum   = $signed({{(33-ENC_W){left_pos[ENC_W-1]}}, left_pos})
                  + $signed({{(33-ENC_W){right_pos[ENC_W-1]}}, right_pos});
        // target * 256 - sum * 128
        err_next  = $signed({target_pos[POS_W-1], target_pos, 8'd0})
                  - $signed({pos_sum[32], pos_sum, 7'd0});
        dist_off  = distance - DIST_W'(10);
        ramp_next = 22'(dist_off[5:0] * max_speed);
        far_next  = distance > DIST_W'(50);
        near_next = distance < DIST_W'(10);

        cmd_prod_next = $signed({{17{err_reg[40]}}, err_reg}) * $signed({42'd0, gain});
        ramp_prod     = {28'd0, ramp_reg} * {22'd0, DIV5_MUL};
        if (far_reg) begin
            lim_next = {max_speed, 8'd0};
        end else if (near_reg) begin
            lim_next = '0;
        end else begin
            // (d - 10) * max * 256 / 40 = (d - 10) * max * 32 / 5
            lim_next = ramp_prod[48:25];
        end

        cmd = cmd_prod_reg[57:8];
        if (cmd[49]) begin
            target_next = '0;
        end else if (cmd > $signed({26'd0, lim_reg})) begin
            target_next = lim_reg;
        end else begin
            target_next = cmd[TGT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.prep) begin
            err_reg  <= err_next;
            ramp_reg <= ramp_next;
            far_reg  <= far_next;
            near_reg <= near_next;
        end
        if (ctl.mult) begin
            cmd_prod_reg <= cmd_prod_next;
            lim_reg      <= lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (ctl.commit) begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule

// File: rtl/dwcp_lane.sv
// One wheel lane: speed estimate, 3-tap average and PI with conditional anti-windup.
// Depends on dwcp_pkg.
module dwcp_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dwcp_pkg::lane_ctl_t         ctl,
    input  logic [dwcp_pkg::ENC_W-1:0]  pos,
    input  logic [dwcp_pkg::GAIN_W-1:0] kp,
    input  logic [dwcp_pkg::GAIN_W-1:0] kid,
    input  logic [dwcp_pkg::TGT_W-1:0]  target,
    output logic [dwcp_pkg::PWM_W-1:0]  pwm
);
    import dwcp_pkg::*;

    logic [ENC_W-1:0]          prev_reg;
    logic signed [HIST_W-1:0]  hist0_reg, hist1_reg;
    logic signed [ENC_W-1:0]   delta;
    logic signed [HIST_W-1:0]  raw_next;
    logic signed [25:0]        hsum_next, hsum_reg;
    logic signed [41:0]        avg_prod;
    logic signed [24:0]        filt_next, filt_reg;
    logic signed [25:0]        err_next, err_reg;
    logic signed [58:0]        iprod_next, iprod_reg, pprod_next, pprod_reg;
    logic signed [34:0]        inc;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W-1:0] integ_next, integ_new_reg, integ_reg;
    logic signed [42:0]        p_next, p_reg;
    logic signed [49:0]        u;
    logic                      neg_next, neg_reg, high_next, high_reg;
    logic [19:0]               u_low_reg;
    logic [41:0]               scaled_next, scaled_reg;
    logic [40:0]               pwm_q;
    logic [PWM_W-1:0]          pwm_next, pwm_reg;

    always_comb begin
        delta = $signed(pos - prev_reg);
        if (delta > DELTA_SAT) begin
            raw_next = HIST_MAX;
        end else if (delta < -DELTA_SAT) begin
            raw_next = HIST_MIN;
        end else begin
            raw_next = $signed({{(HIST_W-12){delta[11]}}, delta[11:0]}) * RAW_MUL;
        end
        hsum_next = $signed({{2{hist0_reg[HIST_W-1]}}, hist0_reg})
                  + $signed({{2{hist1_reg[HIST_W-1]}}, hist1_reg})
                  + $signed({{2{raw_next[HIST_W-1]}}, raw_next});

        avg_prod  = $signed({{16{hsum_reg[25]}}, hsum_reg}) * AVG_MUL;
        filt_next = avg_prod[40:16];

        err_next = $signed({2'b00, target}) - $signed({filt_reg[24], filt_reg});

        iprod_next = $signed({27'd0, kid}) * $signed({{33{err_reg[25]}}, err_reg});
        pprod_next = $signed({27'd0, kp}) * $signed({{33{err_reg[25]}}, err_reg});

        // Integral step, saturated to 48 bits
        inc  = iprod_reg[58:24];
        isum = $signed({integ_reg[INTEG_W-1], integ_reg})
             + $signed({{(INTEG_W-34){inc[34]}}, inc});
        if (isum[INTEG_W] != isum[INTEG_W-1]) begin
            integ_next = isum[INTEG_W] ? $signed(INTEG_MIN) : $signed(INTEG_MAX);
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
        p_next = pprod_reg[58:16];

        u = $signed({{7{p_reg[42]}}, p_reg})
          + $signed({{2{integ_new_reg[INTEG_W-1]}}, integ_new_reg});
        neg_next  = u[49];
        high_next = !u[49] && (u >= U_HIGH);

        scaled_next = {22'd0, u_low_reg} * {20'd0, SCALE_MUL};

        pwm_q = {PWM_STOP, 32'd0} - scaled_reg[40:0];
        if (neg_reg) begin
            pwm_next = PWM_STOP;
        end else if (high_reg) begin
            pwm_next = '0;
        end else begin
            pwm_next = pwm_q[40:32];
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (ctl.front) begin
            hsum_reg <= hsum_next;
        end
        if (ctl.filt) begin
            filt_reg <= filt_next;
        end
        if (ctl.err) begin
            err_reg <= err_next;
        end
        if (ctl.mult) begin
            iprod_reg <= iprod_next;
            pprod_reg <= pprod_next;
        end
        if (ctl.integ) begin
            integ_new_reg <= integ_next;
            p_reg         <= p_next;
        end
        if (ctl.sum) begin
            neg_reg   <= neg_next;
            high_reg  <= high_next;
            u_low_reg <= u[19:0];
        end
        if (ctl.scale) begin
            scaled_reg <= scaled_next;
        end
        if (ctl.pwm) begin
            pwm_reg <= pwm_next;
        end
    end

    // Wheel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            hist0_reg <= '0;
            hist1_reg <= '0;
            integ_reg <= '0;
        end else begin
            if (ctl.front) begin
                prev_reg  <= pos;
                hist0_reg <= hist1_reg;
                hist1_reg <= raw_next;
            end
            // Saturated output: hold the integral
            if (ctl.scale && !neg_reg && !high_reg) begin
                integ_reg <= integ_new_reg;
            end
        end
    end

    assign pwm = pwm_reg;

endmodule

// File: rtl/dual_wheel_cascaded_pi_drive.sv
// Top level of the dual wheel cascaded PI drive: sequencer, registers, merge stage.
// Depends on dwcp_pkg, dwcp_outer and dwcp_lane.
//
// Usage
//   Input channel (s_*): one beat per 2 ms control tick, carrying both encoder
//   counts, the obstacle distance and the position tick flag.
//   Result channel (m_*): one beat per input beat with both motor compare
//   values (400 stop) and the integer part of the speed target.
//   Configuration: cfg_wr_en writes cfg_wr_data to register cfg_index in the
//   same edge; write only while no tick is in flight.
//   Timing: a step sequencer walks one tick through ten steps after the
//   accepting edge; the two wheel lanes run side by side and the outer step
//   overlaps their front end. The result is shown once the walk ends, and
//   s_ready returns in the same cycle; no new tick is taken before then.
//   Stall: the result sits in an output register; the next tick is taken and
//   worked through while it waits, and the sequencer holds in its last step
//   until the register frees.
//   Reset: aresetn (synchronous, active low) clears the wheel state, the speed
//   target, the sequencer and the result valid flag, and loads the register defaults.
module dual_wheel_cascaded_pi_drive (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dwcp_pkg::POS_W-1:0]     s_left_position,
    input  logic [dwcp_pkg::POS_W-1:0]     s_right_position,
    input  logic [dwcp_pkg::DIST_W-1:0]    s_distance_cm,
    input  logic                           s_position_tick,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dwcp_pkg::PWM_W-1:0]     m_left_pwm,
    output logic [dwcp_pkg::PWM_W-1:0]     m_right_pwm,
    output logic [dwcp_pkg::SPD_W-1:0]     m_speed_setpoint,
    input  logic                           cfg_wr_en,
    input  logic [dwcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwcp_pkg::GAIN_W-1:0]    cfg_wr_data
);
    import dwcp_pkg::*;

    // Sequencer steps
    localparam logic [3:0] STEP_IDLE   = 4'd0;
    localparam logic [3:0] STEP_FRONT  = 4'd1;
    localparam logic [3:0] STEP_FILT   = 4'd2;
    localparam logic [3:0] STEP_TARGET = 4'd3;
    localparam logic [3:0] STEP_ERR    = 4'd4;
    localparam logic [3:0] STEP_MULT   = 4'd5;
    localparam logic [3:0] STEP_INTEG  = 4'd6;
    localparam logic [3:0] STEP_SUM    = 4'd7;
    localparam logic [3:0] STEP_SCALE  = 4'd8;
    localparam logic [3:0] STEP_PWM    = 4'd9;
    localparam logic [3:0] STEP_MERGE  = 4'd10;

    logic [3:0] step_reg, step_next;

    // Configuration registers
    logic [GAIN_W-1:0]  kp_left_reg, ki_dt_left_reg, kp_right_reg, ki_dt_right_reg;
    logic [PGAIN_W-1:0] pos_gain_reg;
    logic [POS_W-1:0]   target_pos_reg;
    logic [SPD_W-1:0]   max_speed_reg;

    // Latched input beat
    logic [ENC_W-1:0]  left_pos_reg, right_pos_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              tick_reg;

    logic              in_beat;
    logic              out_load;
    lane_ctl_t         lane_ctl;
    outer_ctl_t        outer_ctl;
    logic [TGT_W-1:0]  target;
    logic [PWM_W-1:0]  left_pwm, right_pwm;

    logic              out_valid_reg, out_valid_next;
    logic [PWM_W-1:0]  out_left_reg, out_right_reg;
    logic [SPD_W-1:0]  out_speed_reg;

    assign s_ready = (step_reg == STEP_IDLE);
    assign in_beat = s_valid && s_ready;
    // Merge: take both lanes and the target once the output register is free
    assign out_load = (step_reg == STEP_MERGE) && (!out_valid_reg || m_ready);

    always_comb begin
        step_next = step_reg;
        unique case (step_reg)
            STEP_IDLE:   if (in_beat) step_next = STEP_FRONT;
            STEP_FRONT:  step_next = STEP_FILT;
            STEP_FILT:   step_next = STEP_TARGET;
            STEP_TARGET: step_next = STEP_ERR;
            STEP_ERR:    step_next = STEP_MULT;
            STEP_MULT:   step_next = STEP_INTEG;
            STEP_INTEG:  step_next = STEP_SUM;
            STEP_SUM:    step_next = STEP_SCALE;
            STEP_SCALE:  step_next = STEP_PWM;
            STEP_PWM:    step_next = STEP_MERGE;
            STEP_MERGE:  if (out_load) step_next = STEP_IDLE;
            default:     step_next = STEP_IDLE;
        endcase
    end

    always_comb begin
        lane_ctl.front = (step_reg == STEP_FRONT);
        lane_ctl.filt  = (step_reg == STEP_FILT);
        lane_ctl.err   = (step_reg == STEP_ERR);
        lane_ctl.mult  = (step_reg == STEP_MULT);
        lane_ctl.integ = (step_reg == STEP_INTEG);
        lane_ctl.sum   = (step_reg == STEP_SUM);
        lane_ctl.scale = (step_reg == STEP_SCALE);
        lane_ctl.pwm   = (step_reg == STEP_PWM);

        outer_ctl.prep   = (step_reg == STEP_FRONT);
        outer_ctl.mult   = (step_reg == STEP_FILT);
        // The target only moves on a position tick, before the lanes read it
        outer_ctl.commit = (step_reg == STEP_TARGET) && tick_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // Hold the beat for the whole walk through the steps
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            left_pos_reg  <= s_left_position[ENC_W-1:0];
            right_pos_reg <= s_right_position[ENC_W-1:0];
            dist_reg      <= s_distance_cm;
            tick_reg      <= s_position_tick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_left_reg     <= KP_LEFT_RST;
            ki_dt_left_reg  <= KI_DT_LEFT_RST;
            kp_right_reg    <= KP_RIGHT_RST;
            ki_dt_right_reg <= KI_DT_RIGHT_RST;
            pos_gain_reg    <= POS_GAIN_RST;
            target_pos_reg  <= TARGET_POS_RST;
            max_speed_reg   <= MAX_SPEED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KP_LEFT:       kp_left_reg     <= cfg_wr_data;
                REG_KI_DT_LEFT:    ki_dt_left_reg  <= cfg_wr_data;
                REG_KP_RIGHT:      kp_right_reg    <= cfg_wr_data;
                REG_KI_DT_RIGHT:   ki_dt_right_reg <= cfg_wr_data;
                REG_POSITION_GAIN: pos_gain_reg    <= cfg_wr_data[PGAIN_W-1:0];
                REG_TARGET_POS:    target_pos_reg  <= cfg_wr_data;
                REG_MAX_SPEED:     max_speed_reg   <= cfg_wr_data[SPD_W-1:0];
                default:           ;   // unmapped index: drop the write
            endcase
        end
    end

    dwcp_outer u_outer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (outer_ctl),
        .left_pos   (left_pos_reg),
        .right_pos  (right_pos_reg),
        .distance   (dist_reg),
        .gain       (pos_gain_reg),
        .target_pos (target_pos_reg),
        .max_speed  (max_speed_reg),
        .target     (target)
    );

    dwcp_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .pos     (left_pos_reg),
        .kp      (kp_left_reg),
        .kid     (ki_dt_left_reg),
        .target  (target),
        .pwm     (left_pwm)
    );

    dwcp_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .pos     (right_pos_reg),
        .kp      (kp_right_reg),
        .kid     (ki_dt_right_reg),
        .target  (target),
        .pwm     (right_pwm)
    );

    // Output register: a new result replaces one that is taken in the same cycle
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_left_reg  <= left_pwm;
            out_right_reg <= right_pwm;
            out_speed_reg <= target[TGT_W-1:8];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_left_pwm       = out_left_reg;
    assign m_right_pwm      = out_right_reg;
    assign m_speed_setpoint = out_speed_reg;

endmodule

// File: rtl/dwcp_checker.sv
// Port-level checks for the dual wheel cascaded PI drive, bound to the top level.
// Depends on dwcp_pkg and dual_wheel_cascaded_pi_drive.
module dwcp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [dwcp_pkg::PWM_W-1:0]     m_left_pwm,
    input logic [dwcp_pkg::PWM_W-1:0]     m_right_pwm,
    input logic [dwcp_pkg::SPD_W-1:0]     m_speed_setpoint
);
    import dwcp_pkg::*;

    // Compare values never pass the stop value
    a_pwm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_pwm <= PWM_STOP) && (m_right_pwm <= PWM_STOP))
        else $error("compare value above stop");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_pwm)
                                && $stable(m_right_pwm) && $stable(m_speed_setpoint))
        else $error("stalled result beat changed");

    // One tick at a time: an accepted beat closes the input for the next cycles
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken while a tick is in flight");

    // A fresh result frees the input in the same cycle
    a_result_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result shown while still busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind dual_wheel_cascaded_pi_drive dwcp_checker u_dwcp_checker (.*);
